/* rtl/ftqg_pkg.sv */
package ftqg_pkg;

  // Fixed field widths
  localparam int TIME_W      = 32;
  localparam int LEVEL_W     = 2;
  localparam int BUDGET_W    = 12;
  localparam int CPM_W       = 10;
  localparam int LIMIT_W     = 20;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 20;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 80;

  // Opcodes carried in in_tuser
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Quality levels
  localparam logic [LEVEL_W-1:0] LVL_NORMAL  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_REDUCED = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_MINIMUM = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CYCLES_PER_US = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_LIMIT    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_LIMIT    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET_NORMAL = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET_HBLANK = 8'd4;

  // Register reset values
  localparam logic [CPM_W-1:0]    RST_CYCLES_PER_US = 10'd240;
  localparam logic [LIMIT_W-1:0]  RST_SLOW_LIMIT    = 20'd20000;
  localparam logic [LIMIT_W-1:0]  RST_FAST_LIMIT    = 20'd13334;
  localparam logic [BUDGET_W-1:0] RST_BUDGET_NORMAL = 12'd1210;
  localparam logic [BUDGET_W-1:0] RST_BUDGET_HBLANK = 12'd954;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RING,
    S_MEAN,
    S_US_GO,
    S_US,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic ring_upd;
    logic div_start;
    logic div_sel_us;
    logic mean_latch;
    logic judge;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_is_query;
    logic div_done;
  } status_t;

endpackage

/* rtl/ftqg_ram.sv */
module ftqg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ftqg_div.sv */
module ftqg_div #(
  parameter int DVD_W = 35,
  parameter int DVS_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   shifted;
  logic             ge;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    shifted  = {rem_r, quo_r[DVD_W-1]};
    ge       = shifted >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? DVS_W'(shifted - {1'b0, dvs_r}) : DVS_W'(shifted);
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/ftqg_dp.sv */
module ftqg_dp #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ftqg_pkg::cmd_t                    cmd,
  output ftqg_pkg::status_t                 sts,
  input  logic [ftqg_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,
  input  logic                              cfg_valid,
  input  logic [ftqg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ftqg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [ftqg_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int TW    = ftqg_pkg::TIME_W;
  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int SUM_W = TW + $clog2(HISTORY_DEPTH);
  localparam int LW    = ftqg_pkg::LEVEL_W;
  localparam int BW    = ftqg_pkg::BUDGET_W;

  // configuration registers
  logic [ftqg_pkg::CPM_W-1:0]   cpm_r;
  logic [ftqg_pkg::LIMIT_W-1:0] slow_lim_r;
  logic [ftqg_pkg::LIMIT_W-1:0] fast_lim_r;
  logic [BW-1:0]                bud_norm_r;
  logic [BW-1:0]                bud_hb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpm_r      <= ftqg_pkg::RST_CYCLES_PER_US;
      slow_lim_r <= ftqg_pkg::RST_SLOW_LIMIT;
      fast_lim_r <= ftqg_pkg::RST_FAST_LIMIT;
      bud_norm_r <= ftqg_pkg::RST_BUDGET_NORMAL;
      bud_hb_r   <= ftqg_pkg::RST_BUDGET_HBLANK;
    end else if (cfg_valid) begin
      case (cfg_index)
        ftqg_pkg::REG_CYCLES_PER_US: cpm_r      <= cfg_data[ftqg_pkg::CPM_W-1:0];
        ftqg_pkg::REG_SLOW_LIMIT:    slow_lim_r <= cfg_data;
        ftqg_pkg::REG_FAST_LIMIT:    fast_lim_r <= cfg_data;
        ftqg_pkg::REG_BUDGET_NORMAL: bud_norm_r <= cfg_data[BW-1:0];
        ftqg_pkg::REG_BUDGET_HBLANK: bud_hb_r   <= cfg_data[BW-1:0];
        default: ;
      endcase
    end
  end

  // input word latch
  logic          op_r;
  logic [TW-1:0] t_r;
  logic          hb_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_tuser;
      t_r  <= in_tdata[TW-1:0];
      hb_r <= in_tdata[TW];
    end
  end

  // running statistics and governor state
  logic [TW-1:0]    frames_r, frames_nxt;
  logic [TW-1:0]    total_r, total_nxt;
  logic [TW-1:0]    mean_r, mean_nxt;
  logic [TW-1:0]    slow_r, slow_nxt;
  logic [LW-1:0]    level_r, level_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [HISTORY_DEPTH-1:0] vld_r, vld_nxt;

  logic [TW-1:0]    ram_rdata;
  logic [TW-1:0]    old_time;
  logic [SUM_W-1:0] quo;
  logic             div_done;
  logic [SUM_W-1:0] div_dvd;
  logic [TW-1:0]    div_dvs;
  logic [ftqg_pkg::CPM_W-1:0] cpm_eff;
  logic [TW-1:0]    us_den;
  logic             too_slow, too_fast;

  // slot content, empty slots read as zero
  assign old_time = vld_r[ptr_r] ? ram_rdata : '0;

  // cycles to microseconds folds the ring average divide into one divisor
  assign cpm_eff = (cpm_r == '0) ? ftqg_pkg::CPM_W'(1) : cpm_r;
  assign us_den  = TW'(TW'(HISTORY_DEPTH) * {{(TW-ftqg_pkg::CPM_W){1'b0}}, cpm_eff});

  assign div_dvd = cmd.div_sel_us ? sum_r : {{(SUM_W-TW){1'b0}}, total_r};
  assign div_dvs = cmd.div_sel_us ? us_den : frames_r;

  assign too_slow = quo > {{(SUM_W-ftqg_pkg::LIMIT_W){1'b0}}, slow_lim_r};
  assign too_fast = quo < {{(SUM_W-ftqg_pkg::LIMIT_W){1'b0}}, fast_lim_r};

  always_comb begin
    frames_nxt = frames_r;
    total_nxt  = total_r;
    mean_nxt   = mean_r;
    slow_nxt   = slow_r;
    level_nxt  = level_r;
    sum_nxt    = sum_r;
    ptr_nxt    = ptr_r;
    vld_nxt    = vld_r;
    if (cmd.accept && (in_tuser == ftqg_pkg::OP_RECORD)) begin
      frames_nxt = frames_r + 1'b1;
      total_nxt  = total_r + in_tdata[TW-1:0];
    end
    if (cmd.ring_upd) begin
      sum_nxt        = sum_r - {{(SUM_W-TW){1'b0}}, old_time}
                             + {{(SUM_W-TW){1'b0}}, t_r};
      vld_nxt[ptr_r] = 1'b1;
      ptr_nxt        = (ptr_r == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
    end
    // count wrapped to zero gives a zero mean
    if (cmd.mean_latch) begin
      mean_nxt = (frames_r == '0) ? '0 : quo[TW-1:0];
    end
    if (cmd.judge) begin
      if (too_slow) begin
        if (level_r != ftqg_pkg::LVL_MINIMUM) begin
          level_nxt = level_r + 1'b1;
        end
        slow_nxt = slow_r + 1'b1;
      end else if (too_fast) begin
        if (level_r != ftqg_pkg::LVL_NORMAL) begin
          level_nxt = level_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= '0;
      total_r  <= '0;
      mean_r   <= '0;
      slow_r   <= '0;
      level_r  <= ftqg_pkg::LVL_NORMAL;
      sum_r    <= '0;
      ptr_r    <= '0;
      vld_r    <= '0;
    end else begin
      frames_r <= frames_nxt;
      total_r  <= total_nxt;
      mean_r   <= mean_nxt;
      slow_r   <= slow_nxt;
      level_r  <= level_nxt;
      sum_r    <= sum_nxt;
      ptr_r    <= ptr_nxt;
      vld_r    <= vld_nxt;
    end
  end

  // recent frame times
  ftqg_ram #(
    .WIDTH (TW),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.ring_upd),
    .waddr (ptr_r),
    .wdata (t_r),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // shared divider: mean, then microseconds
  ftqg_div #(
    .DVD_W (SUM_W),
    .DVS_W (TW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // sprite budget for queries
  logic [BW-1:0] bud_base;
  logic [BW+1:0] bud_x3;
  logic [BW-1:0] budget;

  assign bud_base = hb_r ? bud_hb_r : bud_norm_r;
  assign bud_x3   = {2'b00, bud_base} + {1'b0, bud_base, 1'b0};

  always_comb begin
    case (level_r)
      ftqg_pkg::LVL_MINIMUM: budget = {1'b0, bud_base[BW-1:1]};
      ftqg_pkg::LVL_REDUCED: budget = bud_x3[BW+1:2];
      default:               budget = bud_base;
    endcase
    if (op_r == ftqg_pkg::OP_RECORD) begin
      budget = '0;
    end
  end

  // output word register
  logic [ftqg_pkg::OUT_TDATA_W-1:0] out_r;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= {2'b00, budget, mean_r, slow_r, level_r};
    end
  end

  assign out_tdata       = out_r;
  assign sts.in_is_query = (in_tuser == ftqg_pkg::OP_QUERY);
  assign sts.div_done    = div_done;

endmodule

/* rtl/ftqg_ctrl.sv */
module ftqg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  ftqg_pkg::status_t sts,
  output ftqg_pkg::cmd_t    cmd
);

  ftqg_pkg::state_t state_r, state_nxt;
  logic             ovld_r, ovld_nxt;
  logic             out_free;

  assign out_free = !ovld_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ftqg_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.in_is_query ? ftqg_pkg::S_EMIT : ftqg_pkg::S_RING;
        end
      end
      ftqg_pkg::S_RING:  state_nxt = ftqg_pkg::S_MEAN;
      ftqg_pkg::S_MEAN: begin
        if (sts.div_done) begin
          state_nxt = ftqg_pkg::S_US_GO;
        end
      end
      ftqg_pkg::S_US_GO: state_nxt = ftqg_pkg::S_US;
      ftqg_pkg::S_US: begin
        if (sts.div_done) begin
          state_nxt = ftqg_pkg::S_EMIT;
        end
      end
      ftqg_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = ftqg_pkg::S_IDLE;
        end
      end
      default: state_nxt = ftqg_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ftqg_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ftqg_pkg::S_RING: begin
        cmd.ring_upd  = 1'b1;
        cmd.div_start = 1'b1;
      end
      ftqg_pkg::S_MEAN:  cmd.mean_latch = sts.div_done;
      ftqg_pkg::S_US_GO: begin
        cmd.div_start  = 1'b1;
        cmd.div_sel_us = 1'b1;
      end
      ftqg_pkg::S_US:    cmd.judge = sts.div_done;
      ftqg_pkg::S_EMIT:  cmd.emit  = out_free;
      default: ;
    endcase
  end

  // output word valid
  always_comb begin
    ovld_nxt = ovld_r;
    if (out_tready) begin
      ovld_nxt = 1'b0;
    end
    if (cmd.emit) begin
      ovld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ftqg_pkg::S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign out_tvalid = ovld_r;

endmodule

/* rtl/frame_time_quality_governor.sv */
// Channel  Direction  Handshake             Payload
// in_      slave      in_tvalid/in_tready   tdata: frame period, hblank flag; tuser: opcode
// out_     master     out_tvalid/out_tready tdata: level, dropped, mean, budget
// cfg_     slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One word is in work at a time. A query goes from accept straight to the emit state
// and then into the output register; a record first passes through the ring, mean and
// microsecond states, with two passes of the shared one-bit-per-cycle divider. Synchronous
// active-low reset; the ring is cleared at once by per-slot valid bits, with no clearing
// pass. A new word is taken while a result waits; a stalled output holds the block in its
// emit state until the output register frees. cfg_ready is always high.
module frame_time_quality_governor #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] frame period in cycles, [32] hblank flag, [39:33] zero
  input  logic [ftqg_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] opcode
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] quality_level, [33:2] dropped_count, [65:34] mean_frame_time,
  // [77:66] cycle_budget, [79:78] zero
  output logic [ftqg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ftqg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ftqg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ftqg_pkg::cmd_t    cmd;
  ftqg_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  ftqg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ftqg_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

endmodule

/* rtl/ftqg_checker.sv */
module ftqg_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ftqg_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // one word in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in work");

  // level saturates at minimum quality
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("quality level out of range");

  // a result needs an accepted word first
  a_no_result_without_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared with no word in work");

endmodule

bind frame_time_quality_governor ftqg_checker u_ftqg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* verif/testbench.sv */
module testbench;

  localparam int HIST_DEPTH     = 8;
  // record path: two passes of the serial divider plus control overhead
  localparam int RECORD_LATENCY = 2 * (32 + $clog2(HIST_DEPTH)) + 6;
  localparam int PHASES         = 9;
  localparam int PHASE_WORDS    = 204;
  localparam int LIMIT_CYCLES   = 2_000_000;
  localparam longint TIME_MAX   = 64'hFFFF_FFFF;

  // one report word, quality_level in the lowest bits
  typedef struct packed {
    logic [ftqg_pkg::BUDGET_W-1:0] budget;
    logic [ftqg_pkg::TIME_W-1:0]   mean;
    logic [ftqg_pkg::TIME_W-1:0]   dropped;
    logic [ftqg_pkg::LEVEL_W-1:0]  level;
  } quality_report_t;

  // how a directed frame time is chosen
  typedef enum logic [1:0] {
    PICK_FIXED,
    PICK_AT_SLOW,
    PICK_AT_FAST
  } frame_pick_t;

  // flavor of a random run of words
  typedef enum logic [2:0] {
    RUN_SLOW,
    RUN_FAST,
    RUN_MID,
    RUN_TIE,
    RUN_NOISE
  } run_kind_t;

  typedef struct {
    frame_pick_t     pick;
    logic            op;
    logic [31:0]     ftime;
    logic            hb;
    bit              typed;
    quality_report_t rep;
  } directed_word_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [ftqg_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             in_tuser   = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [ftqg_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [ftqg_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [ftqg_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  // governor mirror: ring, counters, level and register copies
  logic [ftqg_pkg::TIME_W-1:0]   ring [HIST_DEPTH];
  int                            ring_slot;
  logic [ftqg_pkg::TIME_W-1:0]   frames_logged;
  logic [ftqg_pkg::TIME_W-1:0]   time_sum;
  logic [ftqg_pkg::TIME_W-1:0]   mean_time;
  logic [ftqg_pkg::TIME_W-1:0]   slow_count;
  logic [ftqg_pkg::LEVEL_W-1:0]  level_now;
  logic [ftqg_pkg::CPM_W-1:0]    mhz;
  logic [ftqg_pkg::LIMIT_W-1:0]  slow_us;
  logic [ftqg_pkg::LIMIT_W-1:0]  fast_us;
  logic [ftqg_pkg::BUDGET_W-1:0] budget_norm;
  logic [ftqg_pkg::BUDGET_W-1:0] budget_hb;

  quality_report_t owed_reports [$];
  directed_word_t  directed_words [$];

  int  mismatches    = 0;
  int  words_sent    = 0;
  int  words_checked = 0;
  int  cfg_writes    = 0;
  int  level_rises   = 0;
  int  level_falls   = 0;
  int  limit_ties    = 0;
  int  rx_hold       = 0;
  bit  tx_calm       = 1'b0;
  bit  rx_calm       = 1'b0;

  frame_time_quality_governor #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idle length: mostly short, now and then long
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // frame time that makes the ring average land on target_us, -1 if out of reach
  function automatic longint frame_for_us(input longint target_us);
    longint div, others, lo, tmin, tmax;
    div    = (mhz != 0) ? longint'(mhz) : 64'sd1;
    others = 0;
    for (int k = 0; k < HIST_DEPTH; k++)
      if (k != ring_slot) others = others + longint'(ring[k]);
    lo   = target_us * div * HIST_DEPTH;
    tmin = lo - others;
    tmax = lo + div * HIST_DEPTH - 1 - others;
    if (tmin < 0) tmin = 0;
    if (tmax > TIME_MAX) tmax = TIME_MAX;
    if (tmin > tmax) return -1;
    return tmin + longint'($urandom_range(0, 32'(tmax - tmin)));
  endfunction

  // frame time steering the average slow, fast, between or onto a limit
  function automatic logic [31:0] frame_near(input run_kind_t kind);
    longint div, u, t;
    int     r;
    div = (mhz != 0) ? longint'(mhz) : 64'sd1;
    if (kind == RUN_NOISE) return $urandom();
    if (kind == RUN_TIE) begin
      r = $urandom_range(0, 3);
      case (r)
        0:       t = frame_for_us(slow_us);
        1:       t = frame_for_us(fast_us);
        2:       t = frame_for_us(longint'(slow_us) + 1);
        default: t = frame_for_us((fast_us == 0) ? 0 : longint'(fast_us) - 1);
      endcase
      if (t >= 0) return t[31:0];
    end
    case (kind)
      RUN_SLOW: u = longint'(slow_us) + 1 + $urandom_range(0, slow_us / 2 + 16);
      RUN_FAST: u = (fast_us == 0) ? 0 : $urandom_range(0, fast_us - 1);
      default:  u = $urandom_range(fast_us, slow_us);
    endcase
    t = u * div + $urandom_range(0, 32'(div - 1));
    return (t > TIME_MAX) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  // one governor step: record updates stats and level, query reads the budget
  task automatic advance_governor(input logic op, input logic [31:0] ft, input logic hb,
                                  output quality_report_t rep);
    longint unsigned ring_total, avg, us, div;
    logic [31:0]     base;
    int              k;
    rep = '0;
    if (op == ftqg_pkg::OP_RECORD) begin
      frames_logged = frames_logged + 1'b1;
      time_sum      = time_sum + ft;
      mean_time     = (frames_logged != 0) ? time_sum / frames_logged : '0;
      ring[ring_slot] = ft;
      ring_slot = (ring_slot + 1) % HIST_DEPTH;
      ring_total = 0;
      for (k = 0; k < HIST_DEPTH; k++) ring_total = ring_total + ring[k];
      avg = ring_total / HIST_DEPTH;
      div = (mhz != 0) ? mhz : 1;
      us  = avg / div;
      if (us == slow_us || us == fast_us) limit_ties++;
      if (us > slow_us) begin
        if (level_now < ftqg_pkg::LVL_MINIMUM) begin
          level_now = level_now + 1'b1;
          level_rises++;
        end
        slow_count = slow_count + 1'b1;
      end else if (us < fast_us) begin
        if (level_now > ftqg_pkg::LVL_NORMAL) begin
          level_now = level_now - 1'b1;
          level_falls++;
        end
      end
    end else begin
      base = hb ? budget_hb : budget_norm;
      case (level_now)
        ftqg_pkg::LVL_MINIMUM: rep.budget = ftqg_pkg::BUDGET_W'(base / 2);
        ftqg_pkg::LVL_REDUCED: rep.budget = ftqg_pkg::BUDGET_W'((base * 3) / 4);
        default:               rep.budget = ftqg_pkg::BUDGET_W'(base);
      endcase
    end
    rep.level   = level_now;
    rep.dropped = slow_count;
    rep.mean    = mean_time;
  endtask

  // present one word, wait for the handshake, then log what it owes
  task automatic send_word(input logic op, input logic [31:0] ft, input logic hb,
                           input bit typed, input quality_report_t typed_rep);
    int              gap;
    quality_report_t rep;
    gap = (!tx_calm && $urandom_range(0, 99) < 30) ? idle_span() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{(ftqg_pkg::IN_TDATA_W - ftqg_pkg::TIME_W - 1){1'b0}}, hb, ft};
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_governor(op, ft, hb, rep);
    owed_reports.push_back(typed ? typed_rep : rep);
    words_sent++;
  endtask

  // register write; the caller drops cfg_valid after a batch
  task automatic write_reg(input logic [ftqg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ftqg_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ftqg_pkg::REG_CYCLES_PER_US: mhz         = val[ftqg_pkg::CPM_W-1:0];
      ftqg_pkg::REG_SLOW_LIMIT:    slow_us     = val[ftqg_pkg::LIMIT_W-1:0];
      ftqg_pkg::REG_FAST_LIMIT:    fast_us     = val[ftqg_pkg::LIMIT_W-1:0];
      ftqg_pkg::REG_BUDGET_NORMAL: budget_norm = val[ftqg_pkg::BUDGET_W-1:0];
      ftqg_pkg::REG_BUDGET_HBLANK: budget_hb   = val[ftqg_pkg::BUDGET_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // stop sending and let every owed report come back
  task automatic wait_drained();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (owed_reports.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input frame_pick_t pick, input logic op, input logic [31:0] ft,
                         input logic hb, input bit typed, input logic [1:0] lvl,
                         input logic [31:0] drop, input logic [31:0] mean,
                         input logic [11:0] bud);
    directed_word_t w;
    w.pick  = pick;
    w.op    = op;
    w.ftime = ft;
    w.hb    = hb;
    w.typed = typed;
    w.rep   = {bud, mean, drop, lvl};
    directed_words.push_back(w);
  endtask

  // result side: random stalls, with calm stretches
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_tready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 99) < 15) begin
      rx_hold = idle_span() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each report word with the oldest owed one
  always @(posedge clk) begin : report_check
    quality_report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = quality_report_t'(out_tdata[$bits(quality_report_t)-1:0]);
      if (owed_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report word with nothing owed: %h", got);
      end else begin
        want = owed_reports.pop_front();
        words_checked++;
        if (got.level !== want.level || got.dropped !== want.dropped ||
            got.mean !== want.mean || got.budget !== want.budget) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch %0d (exp/got): level %0d/%0d dropped %0d/%0d %s %0d/%0d %s %0d/%0d",
                     mismatches, want.level, got.level, want.dropped, got.dropped,
                     "mean", want.mean, got.mean, "budget", want.budget, got.budget);
        end
      end
    end
  end

  initial begin
    int          ph, n, len, r;
    logic [19:0] lim;
    longint      t;
    logic [31:0] ft;
    run_kind_t   kind;

    // mirror starts from the reset state
    for (int k = 0; k < HIST_DEPTH; k++) ring[k] = '0;
    ring_slot     = 0;
    frames_logged = '0;
    time_sum      = '0;
    mean_time     = '0;
    slow_count    = '0;
    level_now     = ftqg_pkg::LVL_NORMAL;
    mhz           = ftqg_pkg::RST_CYCLES_PER_US;
    slow_us       = ftqg_pkg::RST_SLOW_LIMIT;
    fast_us       = ftqg_pkg::RST_FAST_LIMIT;
    budget_norm   = ftqg_pkg::RST_BUDGET_NORMAL;
    budget_hb     = ftqg_pkg::RST_BUDGET_HBLANK;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at reset settings: budgets at every level, extremes, limit ties
    add_row(PICK_FIXED, ftqg_pkg::OP_QUERY, 32'd0, 1'b0, 1'b1,
            ftqg_pkg::LVL_NORMAL, '0, '0, 12'd1210);
    add_row(PICK_FIXED, ftqg_pkg::OP_QUERY, 32'hFFFF_FFFF, 1'b1, 1'b1,
            ftqg_pkg::LVL_NORMAL, '0, '0, 12'd954);
    add_row(PICK_FIXED, ftqg_pkg::OP_RECORD, 32'd0, 1'b1, 1'b1,
            ftqg_pkg::LVL_NORMAL, '0, '0, 12'd0);
    add_row(PICK_AT_FAST, ftqg_pkg::OP_RECORD, 32'd3_200_000, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(PICK_AT_SLOW, ftqg_pkg::OP_RECORD, 32'd4_800_000, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(PICK_FIXED, ftqg_pkg::OP_RECORD, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(PICK_FIXED, ftqg_pkg::OP_QUERY,  32'd12345,     1'b0, 1'b0, '0, '0, '0, '0);
    add_row(PICK_FIXED, ftqg_pkg::OP_QUERY,  32'd0,         1'b1, 1'b0, '0, '0, '0, '0);
    add_row(PICK_FIXED, ftqg_pkg::OP_RECORD, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, '0, '0, '0);
    add_row(PICK_FIXED, ftqg_pkg::OP_RECORD, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(PICK_FIXED, ftqg_pkg::OP_QUERY,  32'hAAAA_5555, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(PICK_FIXED, ftqg_pkg::OP_QUERY,  32'h5555_AAAA, 1'b1, 1'b0, '0, '0, '0, '0);
    add_row(PICK_FIXED, ftqg_pkg::OP_RECORD, 32'h8000_0000, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(PICK_FIXED, ftqg_pkg::OP_RECORD, 32'h7FFF_FFFF, 1'b1, 1'b0, '0, '0, '0, '0);
    add_row(PICK_FIXED, ftqg_pkg::OP_RECORD, 32'd1,         1'b0, 1'b0, '0, '0, '0, '0);
    add_row(PICK_FIXED, ftqg_pkg::OP_QUERY,  32'd0,         1'b1, 1'b0, '0, '0, '0, '0);

    foreach (directed_words[i]) begin
      ft = directed_words[i].ftime;
      if (directed_words[i].pick != PICK_FIXED) begin
        t = frame_for_us(directed_words[i].pick == PICK_AT_SLOW ? slow_us : fast_us);
        if (t >= 0) ft = t[31:0];
      end
      send_word(directed_words[i].op, ft, directed_words[i].hb,
                directed_words[i].typed, directed_words[i].rep);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      // new settings only with the block drained
      if (ph != 0) begin
        wait_drained();
        case (ph)
          1: begin
            write_reg(ftqg_pkg::REG_CYCLES_PER_US, 20'd1);
            write_reg(ftqg_pkg::REG_SLOW_LIMIT,    20'd0);
            write_reg(ftqg_pkg::REG_FAST_LIMIT,    20'd0);
            write_reg(ftqg_pkg::REG_BUDGET_NORMAL, 20'd4095);
            write_reg(ftqg_pkg::REG_BUDGET_HBLANK, 20'd0);
          end
          2: begin
            write_reg(ftqg_pkg::REG_CYCLES_PER_US, 20'd1000);
            write_reg(ftqg_pkg::REG_SLOW_LIMIT,    20'd1_000_000);
            write_reg(ftqg_pkg::REG_FAST_LIMIT,    20'd1_000_000);
            write_reg(ftqg_pkg::REG_BUDGET_NORMAL, 20'd0);
            write_reg(ftqg_pkg::REG_BUDGET_HBLANK, 20'd4095);
          end
          3: begin
            // zero divisor acts as one
            write_reg(ftqg_pkg::REG_CYCLES_PER_US, 20'd0);
            write_reg(ftqg_pkg::REG_SLOW_LIMIT,    20'hF_FFFF);
            write_reg(ftqg_pkg::REG_FAST_LIMIT,    20'd0);
            write_reg(ftqg_pkg::REG_BUDGET_NORMAL, 20'($urandom()));
            write_reg(ftqg_pkg::REG_BUDGET_HBLANK, 20'($urandom()));
          end
          PHASES - 1: begin
            write_reg(ftqg_pkg::REG_CYCLES_PER_US, 20'(ftqg_pkg::RST_CYCLES_PER_US));
            write_reg(ftqg_pkg::REG_SLOW_LIMIT,    20'(ftqg_pkg::RST_SLOW_LIMIT));
            write_reg(ftqg_pkg::REG_FAST_LIMIT,    20'(ftqg_pkg::RST_FAST_LIMIT));
            write_reg(ftqg_pkg::REG_BUDGET_NORMAL, 20'(ftqg_pkg::RST_BUDGET_NORMAL));
            write_reg(ftqg_pkg::REG_BUDGET_HBLANK, 20'(ftqg_pkg::RST_BUDGET_HBLANK));
          end
          default: begin
            write_reg(ftqg_pkg::REG_CYCLES_PER_US, ($urandom_range(0, 3) == 0) ?
                      20'($urandom()) : 20'($urandom_range(1, 1000)));
            lim = 20'($urandom_range(0, 1_000_000));
            write_reg(ftqg_pkg::REG_SLOW_LIMIT, lim);
            write_reg(ftqg_pkg::REG_FAST_LIMIT, ($urandom_range(0, 3) == 0) ?
                      20'($urandom_range(0, 1_000_000)) : 20'($urandom_range(0, lim)));
            write_reg(ftqg_pkg::REG_BUDGET_NORMAL, 20'($urandom()));
            write_reg(ftqg_pkg::REG_BUDGET_HBLANK, 20'($urandom()));
          end
        endcase
        // index past the register list must be ignored
        write_reg(ftqg_pkg::CFG_IDX_W'($urandom_range(5, 255)), 20'($urandom()));
        cfg_valid <= 1'b0;
      end

      // runs of words pushing the average slow, fast, between or onto a limit
      n = 0;
      while (n < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 35)      kind = RUN_SLOW;
        else if (r < 65) kind = RUN_FAST;
        else if (r < 75) kind = RUN_MID;
        else if (r < 90) kind = RUN_TIE;
        else             kind = RUN_NOISE;
        len     = $urandom_range(3, 12);
        tx_calm = ($urandom_range(0, 5) == 0);
        rx_calm = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 19) == 0) wait_drained();
        repeat (len) begin
          if ($urandom_range(0, 99) < 20)
            send_word(ftqg_pkg::OP_QUERY, $urandom(), 1'($urandom_range(0, 1)), 1'b0, '0);
          else
            send_word(ftqg_pkg::OP_RECORD, frame_near(kind), 1'($urandom_range(0, 1)),
                      1'b0, '0);
          n++;
        end
      end
    end

    wait_drained();
    repeat (2 * RECORD_LATENCY) @(posedge clk);

    $display("covered %0d words (%0d directed), %0d reports checked, %0d register writes",
             words_sent, directed_words.size(), words_checked, cfg_writes);
    $display("level rose %0d and fell %0d times, %0d slow frames, %0d averages on a limit",
             level_rises, level_falls, slow_count, limit_ties);
    if (mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #(64'd12 * LIMIT_CYCLES);
    $display("testbench failed");
    $finish;
  end

endmodule
